/* hdl/glucose_level_trend_alert_classifier_unit_macros.svh */
// Assertion macros for the glucose level trend alert classifier.
`ifndef GLUCOSE_LEVEL_TREND_ALERT_CLASSIFIER_UNIT_MACROS_SVH
`define GLUCOSE_LEVEL_TREND_ALERT_CLASSIFIER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GLTA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GLTA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/glta_pkg.sv */
// Shared types and constants of the glucose level trend alert classifier.
package glta_pkg;

	localparam int NUM_SLOTS = 16;
	localparam int SLOT_W    = 4;
	localparam int VALUE_W   = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 16;

	localparam logic [VALUE_W-1:0] HYPO_CRIT_RST  = 16'd54;
	localparam logic [VALUE_W-1:0] HYPO_WARN_RST  = 16'd70;
	localparam logic [VALUE_W-1:0] NORM_HIGH_RST  = 16'd180;
	localparam logic [VALUE_W-1:0] HYPER_CRIT_RST = 16'd250;

	// Trend thresholds on the two-step delta (rate in tenths compared with 1 and 2).
	localparam logic signed [VALUE_W:0] TREND_FAST = 17'sd20;
	localparam logic signed [VALUE_W:0] TREND_SLOW = 17'sd10;

	localparam logic [1:0] SEEN_MAX = 2'd3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HYPO_CRIT  = 3'd0,
		REG_HYPO_WARN  = 3'd1,
		REG_NORM_HIGH  = 3'd2,
		REG_HYPER_CRIT = 3'd3,
		REG_ACTIVE     = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_NORMAL   = 2'd0,
		ST_WARNING  = 2'd1,
		ST_CRITICAL = 2'd2,
		ST_OFFLINE  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		TR_UNKNOWN   = 3'd0,
		TR_RISE_FAST = 3'd1,
		TR_RISE      = 3'd2,
		TR_STABLE    = 3'd3,
		TR_FALL      = 3'd4,
		TR_FALL_FAST = 3'd5
	} trend_t;

	typedef enum logic [1:0] {
		AK_HYPO_CRIT  = 2'd0,
		AK_HYPO_WARN  = 2'd1,
		AK_HYPER_CRIT = 2'd2,
		AK_HYPER_WARN = 2'd3
	} alert_kind_t;

	typedef struct packed {
		logic [SLOT_W-1:0]  patient_slot;
		logic [VALUE_W-1:0] glucose_value;
	} sample_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot_out;
		logic [1:0]        level_class;
		logic [2:0]        trend_class;
		logic              alert_raised;
		logic [1:0]        alert_kind;
	} result_t;

	typedef struct packed {
		logic [VALUE_W-1:0] hypo_crit;
		logic [VALUE_W-1:0] hypo_warn;
		logic [VALUE_W-1:0] normal_high;
		logic [VALUE_W-1:0] hyper_crit;
	} limits_t;

	typedef struct packed {
		logic [VALUE_W-1:0] last_value;
		logic [VALUE_W-1:0] older_value;
		logic [1:0]         seen_count;
		status_t            status;
	} slot_hist_t;

	localparam slot_hist_t HIST_RESET = '{
		last_value:  '0,
		older_value: '0,
		seen_count:  '0,
		status:      ST_OFFLINE
	};

endpackage

/* hdl/glta_if.sv */
// Valid/ready channel interfaces for samples and results.
interface glta_sample_if;
	logic              valid;
	logic              ready;
	glta_pkg::sample_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface glta_result_if;
	logic              valid;
	logic              ready;
	glta_pkg::result_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

/* hdl/glta_slot_state.sv */
// Per-slot history register file: one read port, one write port, bulk clear.
module glta_slot_state (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [glta_pkg::NUM_SLOTS-1:0]    clear_mask,
	input  logic [glta_pkg::SLOT_W-1:0]       rd_slot,
	output glta_pkg::slot_hist_t              rd_hist,
	input  logic                              wr_en,
	input  logic [glta_pkg::SLOT_W-1:0]       wr_slot,
	input  glta_pkg::slot_hist_t              wr_hist
);

	glta_pkg::slot_hist_t hist_q [glta_pkg::NUM_SLOTS];

	assign rd_hist = hist_q[rd_slot];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < glta_pkg::NUM_SLOTS; s++) begin
				hist_q[s] <= glta_pkg::HIST_RESET;
			end
		end else begin
			for (int s = 0; s < glta_pkg::NUM_SLOTS; s++) begin
				// Newly activated slots restart from an empty history.
				if (clear_mask[s]) begin
					hist_q[s] <= glta_pkg::HIST_RESET;
				end else if (wr_en && (wr_slot == glta_pkg::SLOT_W'(s))) begin
					hist_q[s] <= wr_hist;
				end
			end
		end
	end

endmodule

/* hdl/glta_classify.sv */
// Level, trend and alert classification of one sample against its slot history.
module glta_classify (
	input  logic [glta_pkg::VALUE_W-1:0] value,
	input  glta_pkg::slot_hist_t         hist,
	input  glta_pkg::limits_t            limits,
	output glta_pkg::status_t            level,
	output glta_pkg::trend_t             trend,
	output logic                         alert_raised,
	output glta_pkg::alert_kind_t        alert_kind,
	output glta_pkg::slot_hist_t         next_hist
);

	logic                                below_crit;
	logic                                below_warn;
	logic                                above_crit;
	logic                                above_warn;
	logic signed [glta_pkg::VALUE_W:0]   delta;

	assign below_crit = value < limits.hypo_crit;
	assign below_warn = value < limits.hypo_warn;
	assign above_crit = value > limits.hyper_crit;
	assign above_warn = value > limits.normal_high;

	assign delta = $signed({1'b0, value}) - $signed({1'b0, hist.older_value});

	always_comb begin
		if (below_crit || above_crit) begin
			level = glta_pkg::ST_CRITICAL;
		end else if (below_warn || above_warn) begin
			level = glta_pkg::ST_WARNING;
		end else begin
			level = glta_pkg::ST_NORMAL;
		end
	end

	// Third sample onward has a trend; the count before this sample is at least two.
	always_comb begin
		if (hist.seen_count < 2'd2) begin
			trend = glta_pkg::TR_UNKNOWN;
		end else if (delta > glta_pkg::TREND_FAST) begin
			trend = glta_pkg::TR_RISE_FAST;
		end else if (delta > glta_pkg::TREND_SLOW) begin
			trend = glta_pkg::TR_RISE;
		end else if (delta < -glta_pkg::TREND_FAST) begin
			trend = glta_pkg::TR_FALL_FAST;
		end else if (delta < -glta_pkg::TREND_SLOW) begin
			trend = glta_pkg::TR_FALL;
		end else begin
			trend = glta_pkg::TR_STABLE;
		end
	end

	always_comb begin
		alert_raised = 1'b0;
		alert_kind   = glta_pkg::AK_HYPO_CRIT;
		if (level != hist.status) begin
			if (below_crit) begin
				alert_raised = 1'b1;
				alert_kind   = glta_pkg::AK_HYPO_CRIT;
			end else if (below_warn) begin
				alert_raised = 1'b1;
				alert_kind   = glta_pkg::AK_HYPO_WARN;
			end else if (above_crit) begin
				alert_raised = 1'b1;
				alert_kind   = glta_pkg::AK_HYPER_CRIT;
			end else if (above_warn) begin
				alert_raised = 1'b1;
				alert_kind   = glta_pkg::AK_HYPER_WARN;
			end
		end
	end

	always_comb begin
		next_hist.older_value = hist.last_value;
		next_hist.last_value  = value;
		next_hist.status      = level;
		if (hist.seen_count == glta_pkg::SEEN_MAX) begin
			next_hist.seen_count = hist.seen_count;
		end else begin
			next_hist.seen_count = hist.seen_count + 2'd1;
		end
	end

endmodule

/* hdl/glucose_level_trend_alert_classifier_unit.sv */
// Top level of the glucose level trend alert classifier.
//
//   channel  | dir | payload                                              | beat when
//   ---------+-----+------------------------------------------------------+-------------------
//   sample   | in  | patient_slot, glucose_value                          | valid & ready
//   result   | out | slot_out, level_class, trend_class, alert_raised,    | valid & ready
//            |     | alert_kind                                           |
//   cfg      | in  | cfg_we, cfg_index, cfg_wdata (write only)            | cfg_we high
//
// One sample per cycle sustained while the result register is not stalled. A
// sample waits in the input register, where the slot history is read, classified
// and written back; its result is loaded into the result register once it is
// free. Reset clears all limits to defaults, all slots inactive and all histories
// offline at once. A stalled result holds the input register; samples for inactive
// slots drop there without needing the result register.
module glucose_level_trend_alert_classifier_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	glta_sample_if.sink                     sample,
	glta_result_if.source                   result,
	input  logic                            cfg_we,
	input  logic [glta_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [glta_pkg::CFG_W-1:0]      cfg_wdata
);

	`include "glucose_level_trend_alert_classifier_unit_macros.svh"

	// Configuration registers.
	glta_pkg::limits_t                    limits_q;
	logic [glta_pkg::NUM_SLOTS-1:0]       active_q;
	logic [glta_pkg::NUM_SLOTS-1:0]       clear_mask;

	// Input register stage.
	logic                                 valid_s1;
	logic [glta_pkg::SLOT_W-1:0]          slot_s1;
	logic [glta_pkg::VALUE_W-1:0]         value_s1;
	logic                                 hit_s1;
	logic                                 in_range_s1;

	// Result register.
	logic                                 res_valid_q;
	glta_pkg::result_t                    res_q;

	logic                                 out_free;
	logic                                 advance_s1;
	logic                                 wr_en;

	glta_pkg::slot_hist_t                 rd_hist;
	glta_pkg::slot_hist_t                 next_hist;
	glta_pkg::status_t                    level;
	glta_pkg::trend_t                     trend;
	logic                                 alert_raised;
	glta_pkg::alert_kind_t                alert_kind;

	// Configuration writes: slots whose active bit rises get a fresh history.
	always_comb begin
		clear_mask = '0;
		if (cfg_we && (cfg_index == glta_pkg::REG_ACTIVE)) begin
			clear_mask = cfg_wdata[glta_pkg::NUM_SLOTS-1:0] & ~active_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q.hypo_crit   <= glta_pkg::HYPO_CRIT_RST;
			limits_q.hypo_warn   <= glta_pkg::HYPO_WARN_RST;
			limits_q.normal_high <= glta_pkg::NORM_HIGH_RST;
			limits_q.hyper_crit  <= glta_pkg::HYPER_CRIT_RST;
			active_q             <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				glta_pkg::REG_HYPO_CRIT:  limits_q.hypo_crit   <= cfg_wdata;
				glta_pkg::REG_HYPO_WARN:  limits_q.hypo_warn   <= cfg_wdata;
				glta_pkg::REG_NORM_HIGH:  limits_q.normal_high <= cfg_wdata;
				glta_pkg::REG_HYPER_CRIT: limits_q.hyper_crit  <= cfg_wdata;
				glta_pkg::REG_ACTIVE:     active_q <= cfg_wdata[glta_pkg::NUM_SLOTS-1:0];
				default: begin
					// Unused register index: drop the write.
				end
			endcase
		end
	end

	// Handshake: the input register advances when empty, when its sample drops,
	// or when the result register can take the new result.
	assign in_range_s1 = {1'b0, slot_s1} < (glta_pkg::SLOT_W + 1)'(glta_pkg::NUM_SLOTS);
	assign hit_s1      = valid_s1 && in_range_s1 && active_q[slot_s1];
	assign out_free    = !res_valid_q || result.ready;
	assign advance_s1  = !valid_s1 || !hit_s1 || out_free;
	assign wr_en       = hit_s1 && out_free;

	assign sample.ready = advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance_s1) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && sample.valid) begin
			slot_s1  <= sample.data.patient_slot;
			value_s1 <= sample.data.glucose_value;
		end
	end

	glta_slot_state u_state (
		.clk        (clk),
		.arst_n     (arst_n),
		.clear_mask (clear_mask),
		.rd_slot    (slot_s1),
		.rd_hist    (rd_hist),
		.wr_en      (wr_en),
		.wr_slot    (slot_s1),
		.wr_hist    (next_hist)
	);

	glta_classify u_classify (
		.value        (value_s1),
		.hist         (rd_hist),
		.limits       (limits_q),
		.level        (level),
		.trend        (trend),
		.alert_raised (alert_raised),
		.alert_kind   (alert_kind),
		.next_hist    (next_hist)
	);

	// Result register: load on a hit, drain when the sink takes the beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (wr_en) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			res_q.slot_out     <= slot_s1;
			res_q.level_class  <= level;
			res_q.trend_class  <= trend;
			res_q.alert_raised <= alert_raised;
			res_q.alert_kind   <= alert_kind;
		end
	end

	assign result.valid = res_valid_q;
	assign result.data  = res_q;

	// An alert never comes with a normal level.
	`GLTA_ASSERT_NOW(a_alert_not_normal, clk, arst_n, res_valid_q && res_q.alert_raised, res_q.level_class != glta_pkg::ST_NORMAL, "alert raised with normal level")
	// Every history update produces a result beat.
	`GLTA_ASSERT_NEXT(a_update_gives_result, clk, arst_n, wr_en, res_valid_q, "history updated without result")
	// A dropped sample never produces a result.
	`GLTA_ASSERT_NEXT(a_drop_no_result, clk, arst_n, valid_s1 && !hit_s1 && !res_valid_q, !res_valid_q, "dropped sample produced a result")

endmodule
